@@ rtl/core/rbe_pkg.sv @@
// Shared types and constants for the rotated bitmap expander.
// No dependencies; used by every module of the block and by its checker.
package rbe_pkg;

   localparam int MAX_SRC_WIDTH = 256;
   localparam int MAX_SCR_WIDTH = 4096;

   localparam int SCR_W    = 13;
   localparam int SRCW_W   = 9;
   localparam int ORG_W    = 12;
   localparam int COLOUR_W = 32;
   localparam int OFF_W    = 24;
   localparam int ROW_W    = 8;
   localparam int BCOL_W   = 5;
   localparam int LANES    = 8;
   localparam int IDX_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   // a row also ends when the byte column reaches this limit
   localparam int COL_LIMIT = MAX_SRC_WIDTH / 8;

   localparam logic [SCR_W-1:0]    SCR_WIDTH_RST  = 13'd1024;
   localparam logic [SRCW_W-1:0]   SRC_WIDTH_RST  = 9'd256;
   localparam logic [SRCW_W-1:0]   SRC_HEIGHT_RST = 9'd224;
   localparam logic [COLOUR_W-1:0] COLOUR_RST     = 32'hFFFF_FFFF;

   localparam logic [IDX_W-1:0]  LANE_LAST = IDX_W'(LANES - 1);
   localparam logic [BCOL_W-1:0] BCOL_LAST = '1;
   localparam logic [ROW_W-1:0]  ROW_LAST  = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCR_WIDTH     = 3'd0,
      CSR_SRC_WIDTH     = 3'd1,
      CSR_SRC_HEIGHT    = 3'd2,
      CSR_ORIGIN_X      = 3'd3,
      CSR_ORIGIN_Y      = 3'd4,
      CSR_PIXEL_COLOUR  = 3'd5,
      CSR_CENTER_ENABLE = 3'd6
   } csr_index_type;

   // configuration as seen by the datapath, widths already saturated
   typedef struct packed {
      logic [SCR_W-1:0]    screen_w;
      logic [SRCW_W-1:0]   src_w;
      logic [SRCW_W-1:0]   src_height;
      logic [ORG_W-1:0]    origin_x;
      logic [ORG_W-1:0]    origin_y;
      logic [COLOUR_W-1:0] colour;
      logic                center;
   } cfg_type;

   // one request after address preparation
   typedef struct packed {
      logic [LANES-1:0] bits;
      logic [OFF_W-1:0] drow0;
      logic [OFF_W-1:0] dcol;
   } item_type;

   typedef logic [LANES-1:0][OFF_W-1:0]    lane_off_type;
   typedef logic [LANES-1:0][COLOUR_W-1:0] lane_val_type;

endpackage

@@ rtl/core/rbe_front.sv @@
// Front stage: source row / byte counters and per-request address prep.
// Depends on rbe_pkg.
module rbe_front (
   input  logic                    clock,
   input  logic                    reset,
   input  rbe_pkg::cfg_type        cfg,
   input  logic                    in_valid,
   input  logic [7:0]              in_byte,
   input  logic                    in_start,
   output logic                    in_ready,
   output logic                    out_valid,
   output rbe_pkg::item_type       out_item,
   input  logic                    out_take
);
   import rbe_pkg::*;

   logic [ROW_W-1:0]  row_ff, row_in, row_cur;
   logic [BCOL_W-1:0] bcol_ff, bcol_in, bcol_cur;
   logic              valid_ff, valid_in;
   item_type          item_ff, item_in;
   logic              accept;
   logic [BCOL_W:0]   bcol_inc;
   logic [ROW_W:0]    row_inc;
   logic              end_row, row_wrap;
   logic [OFF_W-1:0]  shift;

   assign in_ready = !valid_ff || out_take;
   assign accept   = in_valid && in_ready;

   always_comb begin
      row_cur  = in_start ? '0 : row_ff;
      bcol_cur = in_start ? '0 : bcol_ff;
      bcol_inc = {1'b0, bcol_cur} + (BCOL_W+1)'(1);
      row_inc  = {1'b0, row_cur} + (ROW_W+1)'(1);
      end_row  = (bcol_inc >= (BCOL_W+1)'(cfg.src_w[SRCW_W-1:3]))
               || (int'(bcol_inc) >= COL_LIMIT) || (bcol_cur == BCOL_LAST);
      row_wrap = (row_inc >= cfg.src_height) || (row_cur == ROW_LAST);

      shift = cfg.center ? (OFF_W'(cfg.screen_w >> 1) - OFF_W'(cfg.src_w >> 1)) : '0;
      item_in.bits  = in_byte;
      item_in.dcol  = OFF_W'(cfg.origin_x) + shift + OFF_W'(row_cur);
      item_in.drow0 = OFF_W'(cfg.origin_y) + OFF_W'(cfg.src_w)
                    - OFF_W'({bcol_cur, 3'b000});

      row_in   = row_ff;
      bcol_in  = bcol_ff;
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
         if (end_row) begin
            bcol_in = '0;
            row_in  = row_wrap ? '0 : row_inc[ROW_W-1:0];
         end else begin
            bcol_in = bcol_inc[BCOL_W-1:0];
            row_in  = row_cur;
         end
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         bcol_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         bcol_ff  <= bcol_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ rtl/core/rbe_lane.sv @@
// One pixel lane: offset of bit LANE from the byte's base offset, and its value.
// Depends on rbe_pkg.
module rbe_lane #(
   parameter int LANE = 0
) (
   input  logic [rbe_pkg::OFF_W-1:0]    base,
   input  logic [rbe_pkg::SCR_W-1:0]    screen_w,
   input  logic                         bit_set,
   input  logic [rbe_pkg::COLOUR_W-1:0] colour,
   output logic [rbe_pkg::OFF_W-1:0]    offset,
   output logic [rbe_pkg::COLOUR_W-1:0] value
);
   import rbe_pkg::*;

   localparam logic [OFF_W-1:0] LANE_K = OFF_W'(LANE);

   // column c+LANE lands LANE rows above column c
   assign offset = base - (LANE_K * OFF_W'(screen_w));
   assign value  = bit_set ? colour : '0;

endmodule

@@ rtl/core/rbe_merge.sv @@
// Merge stage: holds the eight lane results and sends one per cycle while rsp_stall is low.
// Depends on rbe_pkg.
module rbe_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  rbe_pkg::lane_off_type             lane_off,
   input  rbe_pkg::lane_val_type             lane_val,
   output logic                              free,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rbe_pkg::OFF_W-1:0]         rsp_pixel_offset,
   output logic [rbe_pkg::COLOUR_W-1:0]      rsp_pixel_value,
   output logic                              rsp_last_of_byte
);
   import rbe_pkg::*;

   lane_off_type     off_ff;
   lane_val_type     val_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic             last;

   assign last = (idx_ff == LANE_LAST);
   assign free = !valid_ff || (!rsp_stall && last);

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (valid_ff && !rsp_stall) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         off_ff <= lane_off;
         val_ff <= lane_val;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pixel_offset = off_ff[idx_ff];
   assign rsp_pixel_value  = val_ff[idx_ff];
   assign rsp_last_of_byte = last;

endmodule

@@ rtl/core/rotated_bitmap_expander_top.sv @@
// Top level of the rotated bitmap expander: configuration registers, base
// offset multiply, eight pixel lanes. Depends on rbe_pkg, rbe_front, rbe_lane, rbe_merge.
//
// Takes a 1bpp source bitmap one byte per request (row-major, bit 0 leftmost)
// and produces eight framebuffer writes per byte, image turned -90 degrees:
// source (row r, column c) goes to screen row origin_y + W - c, screen column
// origin_x + shift + r, offset = row * S + column modulo 2^24. S and W are the
// screen and source width registers saturated at 4096 and 256; shift is
// S/2 - W/2 when center_enable is set. Writes come out for bits 0..7 in order,
// one per cycle while rsp_stall is low, with rsp_last_of_byte on the eighth.
// Request throughput is bounded by the single result port, which carries eight
// writes per byte; requests are taken while an earlier byte is still draining
// (up to three bytes in flight). A request passes the counter/address stage,
// the base multiply (24x13) register, then its lane results land in the output
// buffer, from which rsp_ is driven. No clearing pass after reset.
// Configuration writes are always ready and must only be issued while the block
// is idle. req_start_block resets the row and byte counters before its byte is
// used; otherwise they advance per byte and wrap at the end of the bitmap.
module rotated_bitmap_expander_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_pixel_byte,
   input  logic                              req_start_block,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rbe_pkg::OFF_W-1:0]         rsp_pixel_offset,
   output logic [rbe_pkg::COLOUR_W-1:0]      rsp_pixel_value,
   output logic                              rsp_last_of_byte,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rbe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rbe_pkg::CSR_DATA_W-1:0]    csr_data
);
   import rbe_pkg::*;

   // configuration registers
   logic [SCR_W-1:0]    scr_width_ff;
   logic [SRCW_W-1:0]   src_width_ff;
   logic [SRCW_W-1:0]   src_height_ff;
   logic [ORG_W-1:0]    origin_x_ff;
   logic [ORG_W-1:0]    origin_y_ff;
   logic [COLOUR_W-1:0] colour_ff;
   logic                center_ff;
   cfg_type             cfg;

   // front stage
   logic     front_ready;
   logic     front_valid;
   item_type front_item;

   // base offset stage
   logic             s2_valid_ff, s2_valid_in;
   logic [OFF_W-1:0] base_ff, base_in;
   logic [LANES-1:0] bits_ff;
   logic             s2_load, s2_free;
   logic [OFF_W+SCR_W-1:0] prod;

   // lanes and merge
   lane_off_type lane_off;
   lane_val_type lane_val;
   logic         merge_free, merge_load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_width_ff  <= SCR_WIDTH_RST;
         src_width_ff  <= SRC_WIDTH_RST;
         src_height_ff <= SRC_HEIGHT_RST;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         colour_ff     <= COLOUR_RST;
         center_ff     <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCR_WIDTH:     scr_width_ff  <= csr_data[SCR_W-1:0];
            CSR_SRC_WIDTH:     src_width_ff  <= csr_data[SRCW_W-1:0];
            CSR_SRC_HEIGHT:    src_height_ff <= csr_data[SRCW_W-1:0];
            CSR_ORIGIN_X:      origin_x_ff   <= csr_data[ORG_W-1:0];
            CSR_ORIGIN_Y:      origin_y_ff   <= csr_data[ORG_W-1:0];
            CSR_PIXEL_COLOUR:  colour_ff     <= csr_data[COLOUR_W-1:0];
            CSR_CENTER_ENABLE: center_ff     <= csr_data[0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // saturate the widths once; everything downstream sees clamped values
   always_comb begin
      cfg.screen_w   = (int'(scr_width_ff) > MAX_SCR_WIDTH)
                     ? SCR_W'(MAX_SCR_WIDTH) : scr_width_ff;
      cfg.src_w      = (int'(src_width_ff) > MAX_SRC_WIDTH)
                     ? SRCW_W'(MAX_SRC_WIDTH) : src_width_ff;
      cfg.src_height = src_height_ff;
      cfg.origin_x   = origin_x_ff;
      cfg.origin_y   = origin_y_ff;
      cfg.colour     = colour_ff;
      cfg.center     = center_ff;
   end

   rbe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_byte   (req_pixel_byte),
      .in_start  (req_start_block),
      .in_ready  (front_ready),
      .out_valid (front_valid),
      .out_item  (front_item),
      .out_take  (s2_load)
   );

   assign req_stall = !front_ready;

   // base offset of bit 0: drow0 * S + dcol, modulo 2^24
   assign merge_load  = s2_valid_ff && merge_free;
   assign s2_free     = !s2_valid_ff || merge_load;
   assign s2_load     = front_valid && s2_free;
   assign prod        = {{SCR_W{1'b0}}, front_item.drow0}
                      * {{OFF_W{1'b0}}, cfg.screen_w};
   assign base_in     = prod[OFF_W-1:0] + front_item.dcol;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (merge_load) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         base_ff <= base_in;
         bits_ff <= front_item.bits;
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      rbe_lane #(.LANE(g)) u_lane (
         .base     (base_ff),
         .screen_w (cfg.screen_w),
         .bit_set  (bits_ff[g]),
         .colour   (cfg.colour),
         .offset   (lane_off[g]),
         .value    (lane_val[g])
      );
   end

   rbe_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .load             (merge_load),
      .lane_off         (lane_off),
      .lane_val         (lane_val),
      .free             (merge_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_offset (rsp_pixel_offset),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_last_of_byte (rsp_last_of_byte)
   );

endmodule

@@ rtl/core/rbe_checker.sv @@
// Port-level checker for the rotated bitmap expander, bound to its top level.
// Depends on rbe_pkg and rotated_bitmap_expander_top.
module rbe_port_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [rbe_pkg::OFF_W-1:0]         rsp_pixel_offset,
   input  logic [rbe_pkg::COLOUR_W-1:0]      rsp_pixel_value,
   input  logic                              rsp_last_of_byte,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [rbe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rbe_pkg::CSR_DATA_W-1:0]    csr_data
);
   import rbe_pkg::*;

   logic             req_acc, rsp_acc;
   logic [IDX_W-1:0] cnt_ff;
   logic [2:0]       pend_ff;
   logic [OFF_W-1:0] prev_off_ff;
   logic [SCR_W-1:0] sw_ff, sw_sat;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign sw_sat  = (int'(sw_ff) > MAX_SCR_WIDTH) ? SCR_W'(MAX_SCR_WIDTH) : sw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pend_ff <= '0;
         sw_ff   <= SCR_WIDTH_RST;
      end else begin
         if (rsp_acc) begin
            cnt_ff <= cnt_ff + IDX_W'(1);
         end
         pend_ff <= pend_ff + 3'(req_acc) - 3'(rsp_acc && rsp_last_of_byte);
         if (csr_valid && csr_ready && csr_index == CSR_SCR_WIDTH) begin
            sw_ff <= csr_data[SCR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_acc) begin
         prev_off_ff <= rsp_pixel_offset;
      end
   end

   // stalled write holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_offset)
                                 && $stable(rsp_pixel_value))
      else $error("stalled write changed");

   // last flag marks every eighth write
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_byte == (cnt_ff == LANE_LAST)))
      else $error("last_of_byte out of step");

   // successive writes of one byte step up one screen row
   a_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (cnt_ff != '0) |-> rsp_pixel_offset == prev_off_ff - OFF_W'(sw_sat))
      else $error("offset step within byte wrong");

   // no write without a request behind it
   a_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("write without outstanding request");

endmodule

bind rotated_bitmap_expander_top rbe_port_checker u_rbe_checker (.*);
